>>> design/hpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hpt_pkg;

  localparam int WORD_W   = 32;
  localparam int QUO_BITS = 32;
  // Width of an exact dot product sum: three full 64-bit products plus the
  // shifted translation term and the rounding half.
  localparam int SUM_W    = 66;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

>>> design/hpt_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module hpt_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire logic [W-1:0]         din,
  input  wire logic                 pop,
  output logic [W-1:0]              dout,
  output hpt_pkg::q_status_t        status
);
  import hpt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign do_push = push && (count_r != (AW+1)'(DEPTH));
  assign do_pop  = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout         = mem_r[rd_ptr_r];
  assign status.full  = (count_r == (AW+1)'(DEPTH));
  assign status.empty = (count_r == '0);

endmodule
`default_nettype wire

>>> design/hpt_front.sv
`timescale 1ns / 1ps
`default_nettype none
module hpt_front #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      en,
  input  wire logic                                      acc,
  input  wire logic                                      opcode,
  input  wire logic [3:0]                                coef_index,
  input  wire logic signed [hpt_pkg::WORD_W-1:0]         coef_value,
  input  wire logic signed [hpt_pkg::WORD_W-1:0]         point_x,
  input  wire logic signed [hpt_pkg::WORD_W-1:0]         point_y,
  input  wire logic signed [hpt_pkg::WORD_W-1:0]         point_z,
  output logic                                           row_valid,
  output logic [4*(hpt_pkg::SUM_W-FRAC_BITS)-1:0]        row_data
);
  import hpt_pkg::*;

  localparam int RW = SUM_W - FRAC_BITS;
  localparam logic signed [WORD_W-1:0] COEF_ONE = WORD_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0]  HALF     = SUM_W'(1) << (FRAC_BITS - 1);

  logic signed [WORD_W-1:0] matrix_r [16];
  logic signed [WORD_W-1:0] pt [3];
  logic signed [63:0]       prod_nxt [12];
  logic signed [63:0]       prod_r   [12];
  logic signed [WORD_W-1:0] trans_r  [4];
  logic signed [SUM_W-1:0]  sum      [4];
  logic signed [RW-1:0]     row_r    [4];
  logic                     valid1_r, valid2_r;

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  // A load changes the matrix at its own transfer, so a transform accepted
  // earlier has already latched products from the old coefficients.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        matrix_r[i] <= ((i >> 2) == (i & 3)) ? COEF_ONE : '0;
      end
    end else if (acc && (opcode == OP_LOAD)) begin
      matrix_r[coef_index] <= coef_value;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[r*3+c] = matrix_r[r*4+c] * pt[c];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum[r] = SUM_W'(prod_r[r*3]) + SUM_W'(prod_r[r*3+1]) + SUM_W'(prod_r[r*3+2])
             + (SUM_W'(trans_r[r]) <<< FRAC_BITS) + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else if (en) begin
      valid1_r <= acc && (opcode == OP_XFORM);
      valid2_r <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 12; k++) begin
        prod_r[k] <= prod_nxt[k];
      end
      for (int r = 0; r < 4; r++) begin
        trans_r[r] <= matrix_r[r*4+3];
        row_r[r]   <= sum[r][SUM_W-1:FRAC_BITS];
      end
    end
  end

  assign row_valid = valid2_r;
  assign row_data  = {row_r[3], row_r[2], row_r[1], row_r[0]};

endmodule
`default_nettype wire

>>> design/hpt_back.sv
`timescale 1ns / 1ps
`default_nettype none
module hpt_back #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      en,
  input  wire logic                                      in_valid,
  input  wire logic [4*(hpt_pkg::SUM_W-FRAC_BITS)-1:0]   in_data,
  output logic                                           res_valid,
  output logic [3*hpt_pkg::WORD_W+1:0]                   res_data
);
  import hpt_pkg::*;

  localparam int RW = SUM_W - FRAC_BITS;
  localparam int QB = QUO_BITS;
  localparam int NW = RW + FRAC_BITS;
  localparam logic [RW-1:0] W_ONE = RW'(1) << FRAC_BITS;
  localparam logic [WORD_W-1:0] POS_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] NEG_MAX = {1'b1, {(WORD_W-1){1'b0}}};

  logic              vld_r  [QB+1];
  logic              div_r  [QB+1];
  logic [RW-1:0]     d_r    [QB+1];
  logic [2:0]        neg_r  [QB+1];
  logic [2:0]        big_r  [QB+1];
  logic [2:0]        psat_r [QB+1];
  logic [RW-1:0]     rem_r  [QB+1][3];
  logic [QB-1:0]     q_r    [QB+1][3];
  logic [QB-1:0]     nlo_r  [QB+1][3];
  logic [WORD_W-1:0] pass_r [QB+1][3];

  logic [RW-1:0]     w, d0, v, n;
  logic [NW-1:0]     nn;
  logic [NW-QB-1:0]  hi;
  logic              div0;
  logic [2:0]        neg0, big0, psat0;
  logic [RW-1:0]     rem0  [3];
  logic [QB-1:0]     nlo0  [3];
  logic [WORD_W-1:0] pass0 [3];

  logic [RW:0]       t    [QB][3];
  logic [RW:0]       tsub [QB][3];
  logic              ge   [QB][3];

  logic [QB:0]       q33  [3];
  logic [QB:0]       lim  [3];
  logic              rnd  [3];
  logic              ovf  [3];
  logic [WORD_W-1:0] res  [3];
  logic              sat_any;

  // Entry stage: magnitudes, signs, passthrough clamp and the quotient
  // overflow check, which is the top of the dividend against the divisor.
  always_comb begin
    w    = in_data[3*RW +: RW];
    d0   = w[RW-1] ? (~w + 1'b1) : w;
    div0 = (w != '0) && (w != W_ONE);
    v    = '0;
    n    = '0;
    nn   = '0;
    hi   = '0;
    for (int l = 0; l < 3; l++) begin
      v        = in_data[l*RW +: RW];
      n        = v[RW-1] ? (~v + 1'b1) : v;
      nn       = {n, {FRAC_BITS{1'b0}}};
      hi       = nn[NW-1:QB];
      big0[l]  = RW'(hi) >= d0;
      rem0[l]  = RW'(hi);
      nlo0[l]  = nn[QB-1:0];
      neg0[l]  = v[RW-1] ^ w[RW-1];
      if (!v[RW-1] && (|v[RW-2:WORD_W-1])) begin
        pass0[l] = POS_MAX;
        psat0[l] = 1'b1;
      end else if (v[RW-1] && !(&v[RW-2:WORD_W-1])) begin
        pass0[l] = NEG_MAX;
        psat0[l] = 1'b1;
      end else begin
        pass0[l] = v[WORD_W-1:0];
        psat0[l] = 1'b0;
      end
    end
  end

  // One restoring quotient bit per stage.
  always_comb begin
    for (int k = 0; k < QB; k++) begin
      for (int l = 0; l < 3; l++) begin
        t[k][l]    = {rem_r[k][l], nlo_r[k][l][QB-1]};
        tsub[k][l] = t[k][l] - {1'b0, d_r[k]};
        ge[k][l]   = t[k][l] >= {1'b0, d_r[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QB; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 0; k < QB; k++) begin
        vld_r[k+1] <= vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0]  <= div0;
      d_r[0]    <= d0;
      neg_r[0]  <= neg0;
      big_r[0]  <= big0;
      psat_r[0] <= psat0;
      for (int l = 0; l < 3; l++) begin
        rem_r[0][l]  <= rem0[l];
        q_r[0][l]    <= '0;
        nlo_r[0][l]  <= nlo0[l];
        pass_r[0][l] <= pass0[l];
      end
      for (int k = 0; k < QB; k++) begin
        div_r[k+1]  <= div_r[k];
        d_r[k+1]    <= d_r[k];
        neg_r[k+1]  <= neg_r[k];
        big_r[k+1]  <= big_r[k];
        psat_r[k+1] <= psat_r[k];
        for (int l = 0; l < 3; l++) begin
          rem_r[k+1][l]  <= ge[k][l] ? tsub[k][l][RW-1:0] : t[k][l][RW-1:0];
          q_r[k+1][l]    <= {q_r[k][l][QB-2:0], ge[k][l]};
          nlo_r[k+1][l]  <= {nlo_r[k][l][QB-2:0], 1'b0};
          pass_r[k+1][l] <= pass_r[k][l];
        end
      end
    end
  end

  // Round half away from zero on the magnitude, then clamp by sign.
  always_comb begin
    sat_any = 1'b0;
    for (int l = 0; l < 3; l++) begin
      rnd[l] = {rem_r[QB][l], 1'b0} >= {1'b0, d_r[QB]};
      q33[l] = {1'b0, q_r[QB][l]} + (QB+1)'(rnd[l]);
      lim[l] = neg_r[QB][l] ? {2'b01, {(QB-1){1'b0}}} : {2'b00, {(QB-1){1'b1}}};
      ovf[l] = big_r[QB][l] || (q33[l] > lim[l]);
      if (!div_r[QB]) begin
        res[l]  = pass_r[QB][l];
        sat_any = sat_any | psat_r[QB][l];
      end else if (ovf[l]) begin
        res[l]  = neg_r[QB][l] ? NEG_MAX : POS_MAX;
        sat_any = 1'b1;
      end else begin
        res[l] = neg_r[QB][l] ? (~q33[l][WORD_W-1:0] + 1'b1) : q33[l][WORD_W-1:0];
      end
    end
  end

  assign res_valid = vld_r[QB];
  assign res_data  = {res[0], res[1], res[2], div_r[QB], sat_any};

endmodule
`default_nettype wire

>>> design/homogeneous_point_transform.sv
// Path: an input passes the front registers, the middle queue, the quotient
// pipeline and the result queue, and waits longer while a queue holds older items.
// Throughput: one item per cycle unless a full queue stalls; the 32-stage quotient
// pipeline and the multiply and sum stages each take a new item every enabled cycle.
// Reset: synchronous, active low; both queues empty, the matrix is the identity.
`timescale 1ns / 1ps
`default_nettype none
module homogeneous_point_transform #(
  parameter int FRAC_BITS = 16,
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_push,
  output logic                                   in_full,
  input  wire logic                              in_opcode,
  input  wire logic [3:0]                        in_coef_index,
  input  wire logic signed [hpt_pkg::WORD_W-1:0] in_coef_value,
  input  wire logic signed [hpt_pkg::WORD_W-1:0] in_point_x,
  input  wire logic signed [hpt_pkg::WORD_W-1:0] in_point_y,
  input  wire logic signed [hpt_pkg::WORD_W-1:0] in_point_z,
  output logic                                   out_empty,
  input  wire logic                              out_pop,
  output logic signed [hpt_pkg::WORD_W-1:0]      out_x,
  output logic signed [hpt_pkg::WORD_W-1:0]      out_y,
  output logic signed [hpt_pkg::WORD_W-1:0]      out_z,
  output logic                                   out_was_divided,
  output logic                                   out_saturated
);
  import hpt_pkg::*;

  localparam int RW    = SUM_W - FRAC_BITS;
  localparam int MID_W = 4 * RW;
  localparam int OUT_W = 3 * WORD_W + 2;

  // The front holds the matrix, forms the twelve products and the four
  // rounded row sums. It stalls only when the middle queue is full.
  q_status_t        mid_stat, out_stat;
  logic             en_front, en_back, acc;
  logic             row_valid;
  logic [MID_W-1:0] row_data, mid_dout;
  logic             res_valid;
  logic [OUT_W-1:0] res_data, out_dout;

  assign en_front = !mid_stat.full;
  assign in_full  = mid_stat.full;
  assign acc      = in_push && !in_full;

  hpt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en_front),
    .acc        (acc),
    .opcode     (in_opcode),
    .coef_index (in_coef_index),
    .coef_value (in_coef_value),
    .point_x    (in_point_x),
    .point_y    (in_point_y),
    .point_z    (in_point_z),
    .row_valid  (row_valid),
    .row_data   (row_data)
  );

  // The middle queue lets the front keep taking points while the divider
  // pipeline is held by a full result queue, and the other way round.
  hpt_queue #(.W(MID_W), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (row_valid && en_front),
    .din    (row_data),
    .pop    (en_back),
    .dout   (mid_dout),
    .status (mid_stat)
  );

  // The back decides on the perspective divide, runs the quotient one bit
  // per stage for all three coordinates, then rounds and clamps.
  assign en_back = !out_stat.full;

  hpt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en_back),
    .in_valid  (!mid_stat.empty),
    .in_data   (mid_dout),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  // Finished results wait here for their transfer, so the pipeline keeps
  // moving while the consumer is briefly slow.
  hpt_queue #(.W(OUT_W), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res_valid && en_back),
    .din    (res_data),
    .pop    (out_pop),
    .dout   (out_dout),
    .status (out_stat)
  );

  assign out_empty       = out_stat.empty;
  assign out_x           = out_dout[OUT_W-1 -: WORD_W];
  assign out_y           = out_dout[OUT_W-1-WORD_W -: WORD_W];
  assign out_z           = out_dout[OUT_W-1-2*WORD_W -: WORD_W];
  assign out_was_divided = out_dout[1];
  assign out_saturated   = out_dout[0];

endmodule
`default_nettype wire

>>> tb/homogeneous_point_transform_tb.sv
`timescale 1ns / 1ps
module homogeneous_point_transform_tb;
  import hpt_pkg::*;

  localparam int FRAC = 16;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT = 20000;

  // One transformed point as the block should present it.
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic divided;
    logic sat;
  } xform_result_t;

  // The scoreboard holds its own copy of the matrix and the queue of pending
  // transformed points, oldest first.
  class xform_scoreboard;
    logic signed [31:0] coefs[16];
    xform_result_t pending[$];
    int mismatches;
    int loads;
    int points;
    int divided_seen;
    int sat_seen;

    function void reset_matrix();
      for (int i = 0; i < 16; i++) begin
        coefs[i] = (i % 5 == 0) ? 32'sd65536 : 32'sd0;
      end
    endfunction

    // Exact row dot product with [x, y, z, 1], rounded to FRAC bits with
    // halves going toward plus infinity. An arithmetic shift of x + half
    // rounds exactly that way.
    function automatic logic signed [127:0] row_dot(int r, logic signed [31:0] px,
                                                     logic signed [31:0] py,
                                                     logic signed [31:0] pz);
      logic signed [127:0] acc;
      acc = 128'(coefs[r*4]) * 128'(px) + 128'(coefs[r*4+1]) * 128'(py)
          + 128'(coefs[r*4+2]) * 128'(pz) + (128'(coefs[r*4+3]) <<< FRAC);
      acc = acc + (128'sd1 <<< (FRAC - 1));
      return acc >>> FRAC;
    endfunction

    function automatic logic signed [31:0] clamp(logic signed [127:0] v, ref logic sat);
      if (v > 128'sh7FFFFFFF) begin
        sat = 1'b1;
        return 32'sh7FFFFFFF;
      end
      if (v < -128'sh80000000) begin
        sat = 1'b1;
        return 32'sh80000000;
      end
      return v[31:0];
    endfunction

    // (v << FRAC) / w on magnitudes, rounded half away from zero.
    function automatic logic signed [31:0] divide(logic signed [127:0] v,
                                                  logic signed [127:0] w, ref logic sat);
      logic [127:0] n, d, q, rem;
      logic neg;
      neg = (v < 0) != (w < 0);
      n = (v < 0) ? -v : v;
      d = (w < 0) ? -w : w;
      n = n << FRAC;
      q = n / d;
      rem = n % d;
      if (rem >= d - rem) q = q + 1;
      if (q > (neg ? 128'h80000000 : 128'h7FFFFFFF)) begin
        sat = 1'b1;
        return neg ? 32'sh80000000 : 32'sh7FFFFFFF;
      end
      return neg ? -q[31:0] : q[31:0];
    endfunction

    function void note_input(logic op, logic [3:0] idx, logic signed [31:0] val,
                             logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz);
      logic signed [127:0] v[3];
      logic signed [127:0] w;
      xform_result_t res;
      logic sat;
      logic dv;
      if (op == OP_LOAD) begin
        coefs[idx] = val;
        loads++;
        return;
      end
      for (int k = 0; k < 3; k++) v[k] = row_dot(k, px, py, pz);
      w = row_dot(3, px, py, pz);
      sat = 1'b0;
      dv = (w != 0) && (w != (128'sd1 <<< FRAC));
      res.x = dv ? divide(v[0], w, sat) : clamp(v[0], sat);
      res.y = dv ? divide(v[1], w, sat) : clamp(v[1], sat);
      res.z = dv ? divide(v[2], w, sat) : clamp(v[2], sat);
      res.divided = dv;
      res.sat = sat;
      pending.insert(pending.size(), res);
      points++;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h, want %h", what, got, want);
      mismatches++;
    endtask

    task check_result(logic signed [31:0] x, logic signed [31:0] y,
                      logic signed [31:0] z, logic dv, logic sat);
      xform_result_t e;
      if (pending.size() == 0) begin
        report("unexpected result", x, 0);
        return;
      end
      e = pending.pop_front();
      if (x !== e.x) report("out_x", x, e.x);
      if (y !== e.y) report("out_y", y, e.y);
      if (z !== e.z) report("out_z", z, e.z);
      if (dv !== e.divided) report("out_was_divided", dv, e.divided);
      if (sat !== e.sat) report("out_saturated", sat, e.sat);
      if (e.divided) divided_seen++;
      if (e.sat) sat_seen++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_opcode = 1'b0;
  logic [3:0] in_coef_index = '0;
  logic signed [31:0] in_coef_value = '0;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic signed [31:0] in_point_z = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic out_was_divided, out_saturated;

  xform_scoreboard sb;
  int idle_cycles = 0;
  int cycle_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  homogeneous_point_transform dut (
    .clk, .rst_n, .in_push, .in_full, .in_opcode, .in_coef_index, .in_coef_value,
    .in_point_x, .in_point_y, .in_point_z, .out_empty, .out_pop, .out_x, .out_y,
    .out_z, .out_was_divided, .out_saturated
  );

  // Both handshakes are sampled at the rising edge, before the nonblocking
  // updates of that edge land, so the scoreboard sees the values the block saw.
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && in_push && !in_full) begin
      sb.note_input(in_opcode, in_coef_index, in_coef_value,
                    in_point_x, in_point_y, in_point_z);
    end
    if (rst_n && out_pop && !out_empty) begin
      sb.check_result(out_x, out_y, out_z, out_was_divided, out_saturated);
    end
    if (rst_n && ((in_push && !in_full) || (out_pop && !out_empty))) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver stalls on a pattern of its own: stretches of steady popping,
  // stretches of random stalls, and one long hold-off that lets the block
  // fill up so that full pushes back on the sender.
  bit long_hold = 1'b0;
  bit hold_requested = 1'b0;
  initial begin
    int mode;
    int len;
    @(posedge clk);
    wait (rst_n);
    forever begin
      if (long_hold) begin
        out_pop <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      mode = $urandom_range(0, 2);
      len = $urandom_range(5, 60);
      repeat (len) begin
        case (mode)
          0: out_pop <= 1'b1;
          1: out_pop <= ($urandom_range(0, 3) != 0);
          default: out_pop <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Offers one item and holds it until the block takes it. push stays high
  // between back-to-back items so no edge sees it dropped and raised.
  task automatic send_item(logic op, logic [3:0] idx, logic signed [31:0] val,
                           logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [31:0] pz);
    in_push <= 1'b1;
    in_opcode <= op;
    in_coef_index <= idx;
    in_coef_value <= val;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic pause_sender(int n);
    in_push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'sh7FFFFFFF;
      2: return 32'sh80000000;
      3: return $signed($urandom_range(0, 8)) <<< 16;
      4: return -($signed($urandom_range(0, 8)) <<< 16);
      default: return $signed(32'($urandom_range(0, 1 << 20))) - 32'sd524288;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'sd0;
      2: return 32'sd65536;
      default: return $signed(32'($urandom_range(0, 1 << 18))) - 32'sd131072;
    endcase
  endfunction

  initial begin
    int sent;
    int burst;
    sb = new();
    sb.reset_matrix();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Identity matrix first: w is exactly one, so points pass
    // through undivided, extremes included.
    send_item(OP_XFORM, 4'd0, 32'sd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sd0);
    send_item(OP_XFORM, 4'hF, 32'shFFFFFFFF, -32'sd1, 32'sd1, 32'sd65536);
    // Zero w: clear the bottom-right coefficient.
    send_item(OP_LOAD, 4'd15, 32'sd0, 32'shFFFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
    send_item(OP_XFORM, 4'd3, 32'sd5, 32'sd12345, -32'sd98765, 32'sh7FFFFFFF);
    // Zero w with a large translation that overflows and clamps.
    send_item(OP_LOAD, 4'd3, 32'sh7FFFFFFF, 32'sd0, 32'sd0, 32'sd0);
    send_item(OP_LOAD, 4'd0, 32'sh7FFFFFFF, 32'sd0, 32'sd0, 32'sd0);
    send_item(OP_XFORM, 4'd0, 32'sd0, 32'sh7FFFFFFF, 32'sd0, 32'sd0);
    // Perspective w = z, ordinary divide.
    send_item(OP_LOAD, 4'd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd0);
    send_item(OP_LOAD, 4'd3, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_item(OP_LOAD, 4'd14, 32'sd65536, 32'sd0, 32'sd0, 32'sd0);
    send_item(OP_XFORM, 4'd0, 32'sd0, 32'sd131072, -32'sd65536, 32'sd196608);
    send_item(OP_XFORM, 4'd0, 32'sd0, 32'sd100000, 32'sd7, -32'sd3);
    // Tiny w gives a huge quotient that saturates on the side of its sign.
    send_item(OP_XFORM, 4'd0, 32'sd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sd1);
    send_item(OP_XFORM, 4'd0, 32'sd0, 32'sh7FFFFFFF, 32'sh80000000, -32'sd1);
    // Fill every coefficient with an extreme, then transform extremes.
    for (int i = 0; i < 16; i++) begin
      send_item(OP_LOAD, 4'(i), (i % 2) ? 32'sh80000000 : 32'sh7FFFFFFF,
                32'sd0, 32'sd0, 32'sd0);
    end
    send_item(OP_XFORM, 4'd0, 32'sd0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
    pause_sender(3);

    // Random part: bursts of items with gaps; mostly transforms, with loads
    // sprinkled in so the matrix keeps changing.
    sent = 0;
    while (sent < 750) begin
      if (sent >= 300 && !hold_requested) begin
        long_hold = 1'b1;
        hold_requested = 1'b1;
      end
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        if ($urandom_range(0, 3) == 0) begin
          send_item(OP_LOAD, 4'($urandom), rand_coef(),
                    $urandom, $urandom, $urandom);
        end else begin
          send_item(OP_XFORM, 4'($urandom), $urandom,
                    rand_word(), rand_word(), rand_word());
        end
        sent++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
    end
    in_push <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d coefficient loads and %0d transformed points in %0d cycles.",
             sb.loads, sb.points, cycle_count);
    $display("Results with perspective divide: %0d, with saturation: %0d.",
             sb.divided_seen, sb.sat_seen);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
